// ----- rtl/imu_fp_pkg.sv -----
// Shared types and constants for the 11-byte serial frame parser.
// Used by imu_fp_cell and imu_frame_parser; depends on nothing else.
package imu_fp_pkg;

	localparam int unsigned FRAME_LEN = 11;
	localparam int unsigned SUM_LEN   = 10;
	localparam int unsigned CNT_W     = 4;

	localparam logic [7:0]       HEADER_BYTE = 8'h55;
	localparam logic [CNT_W-1:0] LAST_POS    = CNT_W'(SUM_LEN);

	// Per-cell control for one accepted beat.
	typedef struct packed {
		logic wr;     // this cell takes the received byte
		logic shift;  // window drops its oldest byte
	} cell_ctl_t;

	// One parsed frame, first field in the lowest bits.
	typedef struct packed {
		logic [15:0] word_three;
		logic [15:0] word_two;
		logic [15:0] word_one;
		logic [15:0] word_zero;
		logic [7:0]  frame_type;
	} result_t;

endpackage

// ----- rtl/imu_fp_cell.sv -----
// One byte position of the parser's shift window.
// Depends on imu_fp_pkg for the control struct.
module imu_fp_cell (
	input  logic                  clk,
	input  imu_fp_pkg::cell_ctl_t ctl,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            upper_byte,
	output logic [7:0]            app_byte
);
	import imu_fp_pkg::*;

	logic [7:0] byte_q;

	// Value after the append: the received byte lands here if this is the fill position.
	assign app_byte = ctl.wr ? rx_byte : byte_q;

	// On a drop the cell takes its upper neighbor's post-append value.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= upper_byte;
		end else begin
			byte_q <= app_byte;
		end
	end

endmodule

// ----- rtl/imu_frame_parser.sv -----
// Top level of the 11-byte header and checksum frame parser.
// Depends on imu_fp_pkg and a row of imu_fp_cell instances.
//
//  channel  | dir | payload (tdata, low bit first)
//  s_axis   | in  | rx_byte[7:0]
//  m_axis   | out | frame_type, word_zero, word_one, word_two, word_three
//
// Each received byte is handled on acceptance: the window row, the fill count and the
// ten-byte checksum tree all settle in the cycle the beat is accepted, so
// bytes may arrive back to back. A completed frame goes to the result register, or
// to the skid slot while m_axis stalls. Reset clears the fill count and both result
// slots; the window bytes are only read once written. A result register plus a skid
// slot keep s_axis open while m_axis stalls; s_axis closes only when both hold frames.
module imu_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // frame_type, word_zero..word_three
);
	import imu_fp_pkg::*;

	logic             in_fire;
	logic             out_fire;
	logic [CNT_W-1:0] held_count_q;
	logic [CNT_W-1:0] pos;
	logic [7:0]       app [FRAME_LEN];
	logic [7:0]       upper [FRAME_LEN];
	cell_ctl_t        ctl [FRAME_LEN];
	logic [7:0]       sum;
	logic             full;
	logic             hdr_ok;
	logic             frame_hit;
	logic             drop;
	result_t          frame;
	result_t          out_q;
	result_t          skid_q;
	logic             out_v_q;
	logic             skid_v_q;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Fill position saturates at the last window slot.
	assign pos = (held_count_q > LAST_POS) ? LAST_POS : held_count_q;

	// Row of window cells; each hands its post-append byte to the cell below.
	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
		assign ctl[i].wr    = in_fire && (pos == CNT_W'(i));
		assign ctl[i].shift = in_fire && drop;
		if (i == FRAME_LEN - 1) begin : g_top
			assign upper[i] = 8'h00;
		end else begin : g_mid
			assign upper[i] = app[i+1];
		end
		imu_fp_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.rx_byte    (s_axis_tdata),
			.upper_byte (upper[i]),
			.app_byte   (app[i])
		);
	end

	// Wrapping checksum of bytes 0..9 as a balanced adder tree.
	always_comb begin
		logic [7:0] p0, p1, p2, p3, p4;
		p0  = app[0] + app[1];
		p1  = app[2] + app[3];
		p2  = app[4] + app[5];
		p3  = app[6] + app[7];
		p4  = app[8] + app[9];
		sum = (p0 + p1) + (p2 + p3) + p4;
	end

	// Frame decision for the byte being accepted.
	assign full      = (pos == LAST_POS);
	assign hdr_ok    = (app[0] == HEADER_BYTE);
	assign frame_hit = in_fire && hdr_ok && full && (sum == app[SUM_LEN]);
	assign drop      = !hdr_ok || (full && (sum != app[SUM_LEN]));

	assign frame.frame_type = app[1];
	assign frame.word_zero  = {app[3], app[2]};
	assign frame.word_one   = {app[5], app[4]};
	assign frame.word_two   = {app[7], app[6]};
	assign frame.word_three = {app[9], app[8]};

	// Fill count: drop leaves the append position, a frame empties the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
		end else if (in_fire) begin
			if (frame_hit) begin
				held_count_q <= '0;
			end else if (drop) begin
				held_count_q <= pos;
			end else begin
				held_count_q <= pos + CNT_W'(1);
			end
		end
	end

	// Result register with a skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out_fire) begin
				out_v_q  <= skid_v_q || frame_hit;
				skid_v_q <= skid_v_q && frame_hit;
			end else begin
				skid_v_q <= skid_v_q || frame_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_fire) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (frame_hit) begin
					skid_q <= frame;
				end
			end else if (frame_hit) begin
				out_q <= frame;
			end
		end else if (frame_hit) begin
			skid_q <= frame;
		end
	end

	assign s_axis_tready = !skid_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	// The fill count never passes the last window slot.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= LAST_POS)
		else $error("fill count out of range");

	// The skid slot is only used behind a full result register.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid slot holds a frame ahead of the result register");

	// A completed frame empties the window.
	a_clear_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_hit |=> (held_count_q == '0))
		else $error("window not cleared after a frame");

	// After a completed frame, m_axis_tvalid is always high on the next cycle.
	a_frame_shown: assert property (@(posedge clk) disable iff (!arst_n)
		frame_hit |=> m_axis_tvalid)
		else $error("frame lost");

endmodule

// ----- test/imu_frame_parser_tb.sv -----
// Self-checking testbench for the 11-byte header and checksum frame parser.
// Drives received bytes into s_axis and checks parsed frames on m_axis against
// a local model of the byte window; depends on imu_fp_pkg and imu_frame_parser.
`timescale 1ns / 100ps

module imu_frame_parser_tb;
	import imu_fp_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned RANDOM_BYTES   = 950;
	localparam int unsigned TOTAL_BYTES    = 1450;
	localparam int unsigned DRAIN_CYCLES   = 8;

	// Kinds of byte sequences in the random stream.
	typedef enum int unsigned {
		SEQ_FRAME,
		SEQ_BAD_SUM,
		SEQ_CUT_SHORT,
		SEQ_NOISE
	} seq_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	// Model of the byte window, oldest byte at index 0.
	logic [7:0]       win_bytes [FRAME_LEN];
	logic [CNT_W-1:0] win_count;

	result_t     pending_frames [$];
	int unsigned bytes_sent     = 0;
	int unsigned frames_checked = 0;
	int unsigned mismatches     = 0;
	int unsigned idle_cycles    = 0;
	bit          send_gaps      = 1'b1;
	bit          recv_gaps      = 1'b1;
	bit          hold_req       = 1'b0;

	imu_frame_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drop the oldest held byte and shift the rest down by one.
	function automatic void drop_front();
		win_count = win_count - 1'b1;
		for (int unsigned i = 0; i + 1 < FRAME_LEN; i++) begin
			if (i < win_count)
				win_bytes[i] = win_bytes[i + 1];
		end
	endfunction

	// Append one byte to the window; returns 1 when a valid frame completes.
	function automatic bit parse_byte(input logic [7:0] rx, output result_t frame);
		int unsigned pos;
		logic [7:0]  sum;
		frame = '0;
		pos = (win_count > SUM_LEN) ? SUM_LEN : win_count;
		win_bytes[pos] = rx;
		win_count = CNT_W'(pos + 1);
		if (win_bytes[0] != HEADER_BYTE) begin
			drop_front();
			return 1'b0;
		end
		if (win_count < FRAME_LEN)
			return 1'b0;
		sum = '0;
		for (int unsigned i = 0; i < SUM_LEN; i++)
			sum = sum + win_bytes[i];
		if (sum != win_bytes[SUM_LEN]) begin
			drop_front();
			return 1'b0;
		end
		frame.frame_type = win_bytes[1];
		frame.word_zero  = {win_bytes[3], win_bytes[2]};
		frame.word_one   = {win_bytes[5], win_bytes[4]};
		frame.word_two   = {win_bytes[7], win_bytes[6]};
		frame.word_three = {win_bytes[9], win_bytes[8]};
		win_count = '0;
		return 1'b1;
	endfunction

	// Header plus nine random body bytes, with the extremes favored.
	function automatic logic [79:0] random_head_body();
		logic [79:0] hb;
		hb = '0;
		hb[7:0] = HEADER_BYTE;
		for (int unsigned k = 1; k < SUM_LEN; k++) begin
			case ($urandom_range(0, 7))
				0:       hb[k*8 +: 8] = 8'h00;
				1:       hb[k*8 +: 8] = 8'hFF;
				default: hb[k*8 +: 8] = 8'($urandom);
			endcase
		end
		return hb;
	endfunction

	// Send one byte on s_axis, with an optional idle burst in front of it.
	task automatic push_rx_byte(input logic [7:0] rx);
		result_t frame;
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 11)) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = rx;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bytes_sent++;
		if (parse_byte(rx, frame))
			pending_frames.push_back(frame);
	endtask

	// Send the first keep bytes of a frame; the checksum is offset by sum_delta.
	task automatic send_frame(input logic [79:0] head_body, input logic [7:0] sum_delta,
			input int unsigned keep);
		logic [7:0] sum;
		sum = '0;
		for (int unsigned k = 0; k < SUM_LEN; k++)
			sum = sum + head_body[k*8 +: 8];
		for (int unsigned k = 0; k < keep; k++) begin
			if (k < SUM_LEN)
				push_rx_byte(head_body[k*8 +: 8]);
			else
				push_rx_byte(sum + sum_delta);
		end
	endtask

	// Random mix of good frames, corrupted or cut frames and line noise.
	task automatic send_random_until(input int unsigned byte_target);
		int unsigned pick;
		seq_kind_t   kind;
		while (bytes_sent < byte_target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				kind = SEQ_FRAME;
			else if (pick < 80)
				kind = SEQ_BAD_SUM;
			else if (pick < 88)
				kind = SEQ_CUT_SHORT;
			else
				kind = SEQ_NOISE;
			case (kind)
				SEQ_FRAME:     send_frame(random_head_body(), 8'h00, FRAME_LEN);
				SEQ_BAD_SUM:   send_frame(random_head_body(), 8'($urandom_range(1, 255)),
						FRAME_LEN);
				SEQ_CUT_SHORT: send_frame(random_head_body(), 8'h00,
						$urandom_range(1, SUM_LEN));
				default: begin
					repeat ($urandom_range(1, 5)) begin
						if ($urandom_range(0, 3) == 0)
							push_rx_byte(HEADER_BYTE);
						else
							push_rx_byte(8'($urandom));
					end
				end
			endcase
		end
	endtask

	// Stop offering bytes, then wait until every predicted frame has been read.
	task automatic wait_frames_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	// Noise, a stray header before a frame, then all-ones and all-zeros frames.
	task automatic test_directed();
		push_rx_byte(8'h00);
		push_rx_byte(8'hFF);
		// The stray header makes the first checksum fail; the parser slips one byte.
		push_rx_byte(HEADER_BYTE);
		send_frame({{9{8'hFF}}, HEADER_BYTE}, 8'h00, FRAME_LEN);
		send_frame({{9{8'h00}}, HEADER_BYTE}, 8'h00, FRAME_LEN);
	endtask

	task automatic test_random_stream();
		send_random_until(RANDOM_BYTES);
	endtask

	// Output held off for a long stretch while frames keep coming back to back,
	// then the sender waits until every frame has been read out.
	task automatic test_output_stall();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		hold_req  = 1'b1;
		repeat (8)
			send_frame(random_head_body(), 8'h00, FRAME_LEN);
		wait_frames_drained();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// Last stretch runs at full rate on both sides.
	task automatic test_back_to_back();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		send_random_until(TOTAL_BYTES);
	endtask

	// Output side: random stall bursts, plus one long hold on request.
	initial begin : recv_side
		int unsigned stall;
		stall = 0;
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
				hold_req = 1'b0;
				stall = 0;
			end else if (stall != 0) begin
				m_axis_tready = 1'b0;
				stall--;
			end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
				m_axis_tready = 1'b0;
				stall = $urandom_range(0, 10);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each frame beat with the oldest predicted frame.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_frames.size() == 0) begin
				$error("frame beat with none predicted: tdata 0x%0h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				compare_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
				compare_field("word_zero", want.word_zero, got.word_zero);
				compare_field("word_one", want.word_one, got.word_one);
				compare_field("word_two", want.word_two, got.word_two);
				compare_field("word_three", want.word_three, got.word_three);
				frames_checked++;
			end
		end
	end

	// Give up when neither side has moved a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Stalled with %0d frames outstanding.", pending_frames.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		win_count     = '0;
		for (int unsigned i = 0; i < FRAME_LEN; i++)
			win_bytes[i] = 8'h00;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_stream();
		test_output_stall();
		test_back_to_back();

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_frames_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Parsed %0d serial bytes into %0d checked frames, with noise, bad checksums,",
			bytes_sent, frames_checked);
		$display("cut frames, random stalls and one long output hold; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending_frames.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/imu_fp_pkg.sv
rtl/imu_fp_cell.sv
rtl/imu_frame_parser.sv
test/imu_frame_parser_tb.sv
